/* rtl/core/egcd_pkg.sv */
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared widths, datapath control types and operation codes for the binary
// extended GCD block.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int VALUE_W = 32;
	localparam int GCD_W   = 32;
	localparam int COEF_W  = 33;

	typedef logic [VALUE_W-1:0]       value_t;
	typedef logic [GCD_W-1:0]         gcd_t;
	typedef logic signed [COEF_W-1:0] coef_t;

	// Operation codes of the shared arithmetic unit.
	localparam logic ALU_HALVE = 1'b0;
	localparam logic ALU_SUB   = 1'b1;

	typedef struct packed {
		logic op;     // ALU_HALVE or ALU_SUB
		logic sel_v;  // 0: works on u and its pair, 1: on v and its pair
	} alu_ctl_t;

	typedef struct packed {
		logic gt;       // u > v
		logic eq;       // u == v
		logic sel_odd;  // selected working value is odd
	} alu_stat_t;

endpackage

/* rtl/core/egcd_if.sv */
// ----------------------------------------------------------------------------
// egcd_if
// Valid/ready stream interfaces for the operand and result channels.
// ----------------------------------------------------------------------------
interface egcd_in_if;
	import egcd_pkg::*;

	logic   valid;
	logic   ready;
	value_t value_a;
	value_t value_b;

	modport source (output valid, output value_a, output value_b, input ready);
	modport sink   (input valid, input value_a, input value_b, output ready);
endinterface

interface egcd_out_if;
	import egcd_pkg::*;

	logic  valid;
	logic  ready;
	gcd_t  gcd;
	coef_t coef_a;
	coef_t coef_b;
	logic  zero_operand;

	modport source (output valid, output gcd, output coef_a, output coef_b,
		output zero_operand, input ready);
	modport sink   (input valid, input gcd, input coef_a, input coef_b,
		input zero_operand, output ready);
endinterface

/* rtl/core/egcd_alu.sv */
// ----------------------------------------------------------------------------
// egcd_alu
// Shared arithmetic unit: subtracts one working value and its coefficient
// pair from the other, or halves a working value and its pair.
// ----------------------------------------------------------------------------
module egcd_alu #(
	parameter int W  = 32,
	parameter int CW = 36
) (
	input  egcd_pkg::alu_ctl_t        ctl,
	input  logic [W-1:0]              a,
	input  logic [W-1:0]              b,
	input  logic [W-1:0]              u,
	input  logic [W-1:0]              v,
	input  logic signed [CW-1:0]      x1,
	input  logic signed [CW-1:0]      x2,
	input  logic signed [CW-1:0]      y1,
	input  logic signed [CW-1:0]      y2,
	output logic [W-1:0]              res_w,
	output logic signed [CW-1:0]      res_c1,
	output logic signed [CW-1:0]      res_c2,
	output egcd_pkg::alu_stat_t       stat
);
	import egcd_pkg::*;

	logic [W-1:0]          sel_w;
	logic [W-1:0]          oth_w;
	logic signed [CW-1:0]  sel_c1;
	logic signed [CW-1:0]  sel_c2;
	logic signed [CW-1:0]  oth_c1;
	logic signed [CW-1:0]  oth_c2;
	logic                  fix;
	logic signed [CW:0]    sum1;
	logic signed [CW:0]    sum2;

	assign sel_w  = ctl.sel_v ? v  : u;
	assign oth_w  = ctl.sel_v ? u  : v;
	assign sel_c1 = ctl.sel_v ? y1 : x1;
	assign sel_c2 = ctl.sel_v ? y2 : x2;
	assign oth_c1 = ctl.sel_v ? x1 : y1;
	assign oth_c2 = ctl.sel_v ? x2 : y2;

	assign stat.gt      = u > v;
	assign stat.eq      = u == v;
	assign stat.sel_odd = sel_w[0];

	// An odd pair is made even by adding b to the first member and taking a
	// from the second, which keeps the pair's value unchanged modulo a*b.
	assign fix  = sel_c1[0] | sel_c2[0];
	assign sum1 = {sel_c1[CW-1], sel_c1}
		+ (fix ? {{(CW+1-W){1'b0}}, b} : {(CW+1){1'b0}});
	assign sum2 = {sel_c2[CW-1], sel_c2}
		- (fix ? {{(CW+1-W){1'b0}}, a} : {(CW+1){1'b0}});

	always_comb begin
		case (ctl.op)
			ALU_SUB: begin
				res_w  = sel_w - oth_w;
				res_c1 = sel_c1 - oth_c1;
				res_c2 = sel_c2 - oth_c2;
			end
			default: begin
				res_w  = {1'b0, sel_w[W-1:1]};
				res_c1 = sum1[CW:1];
				res_c2 = sum2[CW:1];
			end
		endcase
	end

endmodule

/* rtl/core/extended_binary_gcd.sv */
// ----------------------------------------------------------------------------
// extended_binary_gcd
// Binary extended Euclidean GCD with signed Bezout coefficients.
// ----------------------------------------------------------------------------
// One transaction on operands gives one transaction on result. The block
// works on one operand pair at a time and is not ready while it does. A pair
// has its common factors of two stripped first; then each working value is
// halved until it is odd, and subtraction steps, each followed by halving of
// the changed working value, run until the two working values are equal, all
// through a single shared subtract/halve unit, before the result is loaded.
// A zero operand skips these steps and is reported with zero_operand set and
// all other fields zero. The coefficients satisfy
// coef_a*a' + coef_b*b' == gcd >> t, where a' and b' are the operands with
// their t common factors of two removed. A new pair may be accepted while
// the previous result still waits to be taken.
// ----------------------------------------------------------------------------
module extended_binary_gcd #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	egcd_in_if.sink     operands,
	egcd_out_if.source  result
);
	import egcd_pkg::*;

	localparam int OPW = (OPERAND_WIDTH < VALUE_W) ? OPERAND_WIDTH : VALUE_W;
	localparam int CW  = OPW + 4;
	localparam int TW  = $clog2(OPW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_STRIP = 3'd1;
	localparam logic [2:0] ST_HALVE = 3'd2;
	localparam logic [2:0] ST_MAIN  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]            state_q;
	logic [OPW-1:0]        a_q, b_q, u_q, v_q;
	logic signed [CW-1:0]  x1_q, x2_q, y1_q, y2_q;
	logic [TW-1:0]         twos_q;
	logic                  side_q;
	logic                  init_q;
	logic                  err_q;

	logic                  out_valid_q;
	gcd_t                  gcd_q;
	coef_t                 coef_a_q, coef_b_q;
	logic                  zero_q;

	alu_ctl_t              ctl;
	alu_stat_t             stat;
	logic [OPW-1:0]        res_w;
	logic signed [CW-1:0]  res_c1, res_c2;

	logic [OPW-1:0]        in_a, in_b;
	logic                  write_back;
	logic                  wb_side;
	logic                  load_out;
	logic [OPW-1:0]        gcd_sh;
	logic [OPW+GCD_W-1:0]  gcd_ext;
	logic [CW+COEF_W-1:0]  y1_ext, y2_ext;

	assign in_a = operands.value_a[OPW-1:0];
	assign in_b = operands.value_b[OPW-1:0];

	assign operands.ready = (state_q == ST_IDLE);

	always_comb begin
		ctl.op    = ALU_HALVE;
		ctl.sel_v = side_q;
		if (state_q == ST_MAIN) begin
			ctl.op    = ALU_SUB;
			ctl.sel_v = ~stat.gt;
		end
	end

	egcd_alu #(
		.W  (OPW),
		.CW (CW)
	) u_alu (
		.ctl    (ctl),
		.a      (a_q),
		.b      (b_q),
		.u      (u_q),
		.v      (v_q),
		.x1     (x1_q),
		.x2     (x2_q),
		.y1     (y1_q),
		.y2     (y2_q),
		.res_w  (res_w),
		.res_c1 (res_c1),
		.res_c2 (res_c2),
		.stat   (stat)
	);

	assign write_back = ((state_q == ST_HALVE) && !stat.sel_odd)
		|| ((state_q == ST_MAIN) && !stat.eq);
	assign wb_side    = ctl.sel_v;
	assign load_out   = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	assign gcd_sh  = v_q << twos_q;
	assign gcd_ext = {{GCD_W{1'b0}}, gcd_sh};
	assign y1_ext  = {{COEF_W{y1_q[CW-1]}}, y1_q};
	assign y2_ext  = {{COEF_W{y2_q[CW-1]}}, y2_q};

	// Sequencer and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			twos_q  <= '0;
			side_q  <= 1'b0;
			init_q  <= 1'b0;
			err_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (operands.valid) begin
						twos_q <= '0;
						if (in_a == '0 || in_b == '0) begin
							err_q   <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							err_q   <= 1'b0;
							state_q <= ST_STRIP;
						end
					end
				end
				ST_STRIP: begin
					if (!a_q[0] && !b_q[0]) begin
						twos_q <= twos_q + 1'b1;
					end else begin
						side_q  <= 1'b0;
						init_q  <= 1'b1;
						state_q <= ST_HALVE;
					end
				end
				ST_HALVE: begin
					if (stat.sel_odd) begin
						if (init_q && !side_q) begin
							side_q <= 1'b1;
						end else begin
							init_q  <= 1'b0;
							state_q <= ST_MAIN;
						end
					end
				end
				ST_MAIN: begin
					if (stat.eq) begin
						state_q <= ST_DONE;
					end else begin
						side_q  <= ~stat.gt;
						state_q <= ST_HALVE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && operands.valid) begin
			a_q <= in_a;
			b_q <= in_b;
		end else if (state_q == ST_STRIP) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
			end else begin
				u_q  <= a_q;
				v_q  <= b_q;
				x1_q <= CW'(1);
				x2_q <= '0;
				y1_q <= '0;
				y2_q <= CW'(1);
			end
		end else if (write_back) begin
			if (wb_side) begin
				v_q  <= res_w;
				y1_q <= res_c1;
				y2_q <= res_c2;
			end else begin
				u_q  <= res_w;
				x1_q <= res_c1;
				x2_q <= res_c2;
			end
		end
	end

	// Output register: holds a finished result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (err_q) begin
				gcd_q    <= '0;
				coef_a_q <= '0;
				coef_b_q <= '0;
				zero_q   <= 1'b1;
			end else begin
				gcd_q    <= gcd_ext[GCD_W-1:0];
				coef_a_q <= y1_ext[COEF_W-1:0];
				coef_b_q <= y2_ext[COEF_W-1:0];
				zero_q   <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.gcd          = gcd_q;
	assign result.coef_a       = coef_a_q;
	assign result.coef_b       = coef_b_q;
	assign result.zero_operand = zero_q;

	// Once a transaction is taken the block is not ready in the cycle after it.
	assert property (@(posedge clk) disable iff (!arst_n)
		operands.valid && operands.ready |=> !operands.ready)
		else $error("operand accepted while a pair was still in progress");

	// Subtraction steps only ever see two odd working values.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAIN |-> u_q[0] && v_q[0])
		else $error("even working value reached the subtraction step");

	// A pair of nonzero operands never reduces to a zero working value.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HALVE |-> u_q != '0 && v_q != '0)
		else $error("working value collapsed to zero");

	// An error result carries zero in every other field.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.zero_operand |-> result.gcd == '0
			&& result.coef_a == '0 && result.coef_b == '0)
		else $error("zero operand result with nonzero fields");

	// A result is only loaded after the sequencer has reached its final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(state_q) == ST_DONE)
		else $error("result appeared without a finished pair");

endmodule

/* tb/extended_binary_gcd_tb.sv */
// ----------------------------------------------------------------------------
// extended_binary_gcd_tb
// Self-checking bench for the binary extended GCD block. A driver offers
// operand pairs from a queue and predicts the gcd and Bezout coefficients of
// each accepted pair. A monitor compares every result transaction with the
// oldest prediction. Both sides stall at random, the receiver once holds off
// for a long stretch, and the sender twice waits for the block to drain.
// ----------------------------------------------------------------------------
module extended_binary_gcd_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import egcd_pkg::*;

	localparam int OPW          = 32;
	localparam int DIRECTED_N   = 21;
	localparam int RANDOM_N     = 1030;
	localparam int CALM_FROM    = 550;
	localparam int CALM_TO      = 700;
	localparam int STALL_AT     = 400;
	localparam int STALL_CYCLES = 300;
	localparam int SETTLE       = 120;
	localparam int QUIET_LIMIT  = 3000;
	localparam int PRINT_LIMIT  = 40;

	typedef struct {
		value_t a;
		value_t b;
		bit     drain_first;
	} operand_pair_t;

	typedef struct packed {
		gcd_t  gcd;
		coef_t coef_a;
		coef_t coef_b;
		logic  zero_operand;
	} bezout_t;

	logic clk;
	logic arst_n;

	egcd_in_if  opnd ();
	egcd_out_if res ();

	extended_binary_gcd #(.OPERAND_WIDTH(OPW)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.operands (opnd),
		.result   (res)
	);

	operand_pair_t pending_pairs[$];
	bezout_t       awaited_results[$];

	int  pairs_sent    = 0;
	int  results_seen  = 0;
	int  zero_results  = 0;
	int  even_gcds     = 0;
	int  mismatches    = 0;
	int  quiet_cycles  = 0;
	int  stall_left    = 0;
	logic calm;

	assign calm = (pairs_sent >= CALM_FROM) && (pairs_sent < CALM_TO);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Halves one member of a coefficient pair. When the pair is not all even,
	// the first member gains b and the second loses a before the halving.
	function automatic logic [63:0] halved(logic [63:0] c, logic pair_even,
			logic [63:0] corr, logic minus);
		logic [63:0] sh;
		sh = {c[63], c[63:1]};
		if (pair_even)
			return sh;
		if (!minus)
			return sh + (corr >> 1) + 64'(c[0] & corr[0]);
		return sh - (corr >> 1) - 64'(~c[0] & corr[0]);
	endfunction

	function automatic bezout_t bezout_of(value_t op_a, value_t op_b);
		logic [63:0] opmask, a, b, u, v, x1, x2, y1, y2, n1, n2;
		int unsigned twos;
		bezout_t r;
		opmask = (64'd1 << OPW) - 64'd1;
		a = 64'(op_a) & opmask;
		b = 64'(op_b) & opmask;
		twos = 0;
		if (a == 0 || b == 0) begin
			r.gcd = '0;
			r.coef_a = '0;
			r.coef_b = '0;
			r.zero_operand = 1'b1;
			return r;
		end
		while (!a[0] && !b[0]) begin
			a = a >> 1;
			b = b >> 1;
			twos++;
		end
		u = a;
		v = b;
		x1 = 64'd1; x2 = 64'd0;
		y1 = 64'd0; y2 = 64'd1;
		while (!u[0]) begin
			u = u >> 1;
			n1 = halved(x1, !x1[0] && !x2[0], b, 1'b0);
			n2 = halved(x2, !x1[0] && !x2[0], a, 1'b1);
			x1 = n1; x2 = n2;
		end
		while (!v[0]) begin
			v = v >> 1;
			n1 = halved(y1, !y1[0] && !y2[0], b, 1'b0);
			n2 = halved(y2, !y1[0] && !y2[0], a, 1'b1);
			y1 = n1; y2 = n2;
		end
		while (u != v) begin
			if (u > v) begin
				u = u - v;
				x1 = x1 - y1;
				x2 = x2 - y2;
				while (!u[0]) begin
					u = u >> 1;
					n1 = halved(x1, !x1[0] && !x2[0], b, 1'b0);
					n2 = halved(x2, !x1[0] && !x2[0], a, 1'b1);
					x1 = n1; x2 = n2;
				end
			end else begin
				v = v - u;
				y1 = y1 - x1;
				y2 = y2 - x2;
				while (!v[0]) begin
					v = v >> 1;
					n1 = halved(y1, !y1[0] && !y2[0], b, 1'b0);
					n2 = halved(y2, !y1[0] && !y2[0], a, 1'b1);
					y1 = n1; y2 = n2;
				end
			end
		end
		r.gcd = gcd_t'((v << twos) & opmask);
		r.coef_a = coef_t'(y1[COEF_W-1:0]);
		r.coef_b = coef_t'(y2[COEF_W-1:0]);
		r.zero_operand = 1'b0;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: result %0d: %s got 0x%0h, expected 0x%0h",
				$realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic add_pair(value_t a, value_t b, bit drain_first);
		operand_pair_t p;
		p.a = a;
		p.b = b;
		p.drain_first = drain_first;
		pending_pairs.push_back(p);
	endtask

	// Driver: predicts each accepted pair, then offers the next one.
	always @(posedge clk) begin : driver
		operand_pair_t p;
		bit launch;
		if (!arst_n) begin
			opnd.valid <= 1'b0;
		end else begin
			if (opnd.valid && opnd.ready) begin
				awaited_results.push_back(bezout_of(opnd.value_a, opnd.value_b));
				pairs_sent++;
			end
			if (!opnd.valid || opnd.ready) begin
				launch = pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 27);
				// A drain point holds the next pair back until every result is in.
				if (launch && pending_pairs[0].drain_first &&
						(awaited_results.size() != 0 || opnd.valid))
					launch = 1'b0;
				if (launch) begin
					p = pending_pairs.pop_front();
					opnd.valid   <= 1'b1;
					opnd.value_a <= p.a;
					opnd.value_b <= p.b;
				end else begin
					opnd.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transaction and drives ready.
	always @(posedge clk) begin : monitor
		bezout_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				results_seen++;
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no pair pending", 64'(res.gcd), 64'd0);
				end else begin
					want = awaited_results.pop_front();
					if (want.zero_operand)
						zero_results++;
					else if (!want.gcd[0])
						even_gcds++;
					if (res.gcd !== want.gcd)
						report_mismatch("gcd", 64'(res.gcd), 64'(want.gcd));
					if (res.coef_a !== want.coef_a)
						report_mismatch("coef_a", 64'(res.coef_a), 64'(want.coef_a));
					if (res.coef_b !== want.coef_b)
						report_mismatch("coef_b", 64'(res.coef_b), 64'(want.coef_b));
					if (res.zero_operand !== want.zero_operand)
						report_mismatch("zero_operand", 64'(res.zero_operand),
							64'(want.zero_operand));
				end
				if (results_seen == STALL_AT)
					stall_left = STALL_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= calm || $urandom_range(99) >= 27;
			end
		end
	end

	always @(posedge clk) begin
		if ((opnd.valid && opnd.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		value_t a, b, g;
		int mode;
		arst_n       = 1'b0;
		opnd.valid   = 1'b0;
		opnd.value_a = '0;
		opnd.value_b = '0;
		res.ready    = 1'b0;

		// Zero operands, extremes, common twos and a long subtraction chain.
		add_pair(32'h0000_0000, 32'h0000_0000, 1'b0);
		add_pair(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		add_pair(32'h1234_5678, 32'h0000_0000, 1'b0);
		add_pair(32'h0000_0001, 32'h0000_0001, 1'b0);
		add_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_pair(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		add_pair(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
		add_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_pair(32'h8000_0000, 32'h4000_0000, 1'b0);
		add_pair(32'hC000_0000, 32'h8000_0000, 1'b0);
		add_pair(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0);
		add_pair(32'hB119_24E1, 32'h6D73_E55F, 1'b0);
		add_pair(32'h6D73_E55F, 32'hB119_24E1, 1'b0);
		add_pair(32'd2, 32'd3, 1'b0);
		add_pair(32'd6, 32'd4, 1'b0);
		add_pair(32'd12, 32'd18, 1'b0);
		add_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
		add_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
		add_pair(32'd7, 32'h8000_0000, 1'b0);
		add_pair(32'h8000_0000, 32'd7, 1'b0);
		add_pair(32'd48, 32'd180, 1'b0);

		for (int i = 0; i < RANDOM_N; i++) begin
			mode = $urandom_range(99);
			a = $urandom;
			b = $urandom;
			if (mode < 35) begin
				// full-width operands as drawn
			end else if (mode < 55) begin
				g = ($urandom >> $urandom_range(8, 31)) | 32'd1;
				a = (g * ($urandom >> $urandom_range(12, 31))) << $urandom_range(0, 24);
				b = (g * ($urandom >> $urandom_range(12, 31))) << $urandom_range(0, 24);
			end else if (mode < 70) begin
				a = $urandom_range(1, 255);
				b = $urandom_range(1, 255);
			end else if (mode < 80) begin
				a = 32'd1 << $urandom_range(0, 31);
				if ($urandom_range(1))
					{a, b} = {b, a};
			end else if (mode < 85) begin
				case ($urandom_range(2))
					0: a = '0;
					1: b = '0;
					default: begin
						a = '0;
						b = '0;
					end
				endcase
			end else if (mode < 93) begin
				b = $urandom_range(1) ? a : a + 32'd1;
			end else begin
				a = $urandom >> $urandom_range(0, 31);
				b = $urandom >> $urandom_range(0, 31);
			end
			add_pair(a, b, i == 180 || i == 780);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		do @(posedge clk);
		while (pending_pairs.size() != 0 || opnd.valid || awaited_results.size() != 0);
		repeat (SETTLE) @(posedge clk);

		$display("Checked %0d operand pairs: %0d with a zero operand, %0d with common twos.",
			results_seen, zero_results, even_gcds);
		$display("Receiver held off %0d cycles once; sender drained the block twice.",
			STALL_CYCLES);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				awaited_results.size());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
